// File: sv/sme_pkg.sv
// Shared types, register codes and table functions for the stereo modulation effect.
// No dependencies; used by sme_engine and the top level.
`default_nettype none

package sme_pkg;

   // Register port layout
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 19;

   localparam logic [CSR_AW-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_AMOUNT = 3'd1;
   localparam logic [CSR_AW-1:0] REG_STEP   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_CENTER = 3'd3;
   localparam logic [CSR_AW-1:0] REG_SWING  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_BASE   = 3'd5;
   localparam logic [CSR_AW-1:0] REG_SPAN   = 3'd6;

   // Effect modes
   localparam logic [1:0] MODE_BYPASS  = 2'd0;
   localparam logic [1:0] MODE_CHORUS  = 2'd1;
   localparam logic [1:0] MODE_PHASER  = 2'd2;
   localparam logic [1:0] MODE_TREMOLO = 2'd3;

   // pi in Q30 and a quarter circle of LFO phase
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [15:0] QUARTER = 16'd16384;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] amount;
      logic [15:0] step;
      logic [18:0] center;
      logic [18:0] swing;
      logic [14:0] base;
      logic [14:0] span;
   } cfg_type;

   typedef struct packed {
      logic ready;   // engine takes a new beat
      logic done;    // result moves to the output register
   } eng_stat_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LFO,
      ST_T1, ST_T2, ST_T3,
      ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8, ST_C9,
      ST_P1, ST_P2, ST_P3, ST_PRD, ST_PM1, ST_PY, ST_PM2, ST_PWR, ST_POUT,
      ST_NEXT, ST_PUSH
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
      if (v > 52'sd32767) return 16'sh7fff;
      else if (v < -52'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
      if (v > 52'sd8388607) return 24'sh7fffff;
      else if (v < -52'sd8388608) return 24'sh800000;
      else return v[23:0];
   endfunction

   // Sine of r/65536 of a circle, r in [0,16384], Q15, odd Taylor series
   function automatic logic [15:0] quarter_sine(input logic [15:0] r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (64'(r) * PI_Q30) >> 15;
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 64'sd0) sum = 64'sd0;
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) sum = 64'sd32767;
      return sum[15:0];
   endfunction

   function automatic logic signed [15:0] full_sine(input logic [15:0] p);
      logic [15:0]        r;
      logic signed [15:0] v;
      r = {2'b00, p[13:0]};
      v = p[14] ? $signed(quarter_sine(QUARTER - r)) : $signed(quarter_sine(r));
      return p[15] ? -v : v;
   endfunction

   // Allpass coefficient (sin t - cos t)/(sin t + cos t), Q15, toward zero
   function automatic logic signed [15:0] coef_val(input logic [15:0] ang);
      logic signed [31:0] s;
      logic signed [31:0] c;
      logic signed [31:0] num;
      logic [31:0]        den;
      logic [31:0]        mag;
      logic [31:0]        rem;
      logic [31:0]        q;
      logic signed [31:0] a;
      int                 i;
      s   = 32'(quarter_sine(ang));
      c   = 32'(quarter_sine(QUARTER - ang));
      num = (s - c) * 32'sd32768;
      den = 32'(s + c);
      mag = (num < 0) ? 32'(-num) : 32'(num);
      rem = '0;
      q   = '0;
      // restoring divide, evaluated only when the table is built
      for (i = 31; i >= 0; i--) begin
         rem = {rem[30:0], mag[i]};
         q   = q << 1;
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      a = (num < 0) ? -$signed(q) : $signed(q);
      return sat16(52'(a));
   endfunction

endpackage

`default_nettype wire

// File: sv/sme_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module sme_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: sv/sme_engine.sv
// Sequencer and shared datapath: LFO tables, one multiplier, delay and allpass RAMs.
// Depends on sme_pkg and sme_ram.
`default_nettype none

module sme_engine #(
   parameter int DELAY_DEPTH     = 2048,
   parameter int ALLPASS_STAGES  = 4,
   parameter int SINE_TABLE_SIZE = 1024,
   parameter int COEF_TABLE_SIZE = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sme_pkg::cfg_type    cfg,
   input  wire logic                start,
   input  wire logic signed [15:0]  left_in,
   input  wire logic signed [15:0]  right_in,
   input  wire logic                slot_free,
   output sme_pkg::eng_stat_type    stat,
   output logic signed [15:0]       left_out,
   output logic signed [15:0]       right_out
);

   localparam int DW   = $clog2(DELAY_DEPTH);
   localparam int DAW  = $clog2(2 * DELAY_DEPTH);
   localparam int AAW  = $clog2(2 * ALLPASS_STAGES);
   localparam int SW   = $clog2(ALLPASS_STAGES + 1);
   localparam int SIW  = $clog2(SINE_TABLE_SIZE);
   localparam int CIW  = $clog2(COEF_TABLE_SIZE);
   localparam int DMAX = (DELAY_DEPTH - 1) * 256;

   sme_pkg::state_type state_ff, state_in;

   logic              ch_ff, ch_in;
   logic [15:0]       phase_ff, phase_in;
   logic [DW-1:0]     widx_ff, widx_in;
   logic [DAW-1:0]    clr_ff, clr_in;
   logic [SW-1:0]     stg_ff, stg_in;

   logic signed [15:0] xl_ff, xr_ff, yl_ff, yr_ff;
   logic signed [49:0] prod_ff, prod_in;
   logic [DW+7:0]      d_ff;
   logic [DW-1:0]      i0_ff, i1_ff;
   logic [8:0]         frac_ff;
   logic signed [15:0] s0_ff, wet_ff;
   logic [14:0]        f_ff;
   logic signed [23:0] v_ff, s_ff, y24_ff;
   logic signed [15:0] sine_q_ff, coef_q_ff;

   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;

   // RAM ports
   logic              dly_we;
   logic [DAW-1:0]    dly_waddr, dly_raddr;
   logic [15:0]       dly_wdata, dly_rdata;
   logic              ap_we;
   logic [AAW-1:0]    ap_waddr, ap_raddr;
   logic [23:0]       ap_wdata, ap_rdata;

   // datapath helpers
   logic signed [15:0] x_cur;
   logic signed [51:0] d_full, wet_full, chf, yv_full, sn_full;
   logic [DW+7:0]      d_clamp;
   logic [DW:0]        back;
   logic [DW+1:0]      tsum;
   logic [DW-1:0]      i0_c, i1_c;
   logic [8:0]         frac_c;
   logic [16:0]        fsum;
   logic [14:0]        f_cap;
   logic signed [23:0] yv, sn;
   logic               y_we;
   logic signed [15:0] y_val;

   // ---------------- constant tables ----------------
   logic signed [15:0] sine_rom [SINE_TABLE_SIZE];
   logic signed [15:0] coef_rom [COEF_TABLE_SIZE];

   for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_sine
      assign sine_rom[gi] = sme_pkg::full_sine(16'((gi * 65536) / SINE_TABLE_SIZE));
   end
   for (genvar gi = 0; gi < COEF_TABLE_SIZE; gi++) begin : g_coef
      assign coef_rom[gi] = sme_pkg::coef_val(16'((gi * 16384) / COEF_TABLE_SIZE));
   end

   logic [15:0]    lfo_ph;
   logic [31:0]    sine_mul, coef_mul;
   logic [SIW-1:0] sine_idx;
   logic [CIW-1:0] coef_idx;

   // right channel runs a quarter cycle ahead
   assign lfo_ph   = phase_ff + (ch_ff ? sme_pkg::QUARTER : 16'd0);
   assign sine_mul = 32'(lfo_ph) * 32'(SINE_TABLE_SIZE);
   assign sine_idx = sine_mul[16 +: SIW];
   assign coef_mul = 32'(f_ff) * 32'(COEF_TABLE_SIZE);
   assign coef_idx = coef_mul[15 +: CIW];

   // registered table reads
   always_ff @(posedge clock) begin
      sine_q_ff <= sine_rom[sine_idx];
      coef_q_ff <= coef_rom[coef_idx];
   end

   // ---------------- memories ----------------
   sme_ram #(.WIDTH(16), .DEPTH(2 * DELAY_DEPTH)) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (dly_waddr),
      .wr_data (dly_wdata),
      .rd_addr (dly_raddr),
      .rd_data (dly_rdata)
   );

   sme_ram #(.WIDTH(24), .DEPTH(2 * ALLPASS_STAGES)) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_we),
      .wr_addr (ap_waddr),
      .wr_data (ap_wdata),
      .rd_addr (ap_raddr),
      .rd_data (ap_rdata)
   );

   // ---------------- datapath arithmetic ----------------
   always_comb begin
      x_cur = ch_ff ? xr_ff : xl_ff;

      // chorus delay: center + rounded swing*L, clamped to the line
      d_full = $signed(52'(cfg.center)) + ((52'(prod_ff) + 52'sd16384) >>> 15);
      if (d_full < 52'sd0) d_clamp = '0;
      else if (d_full > 52'(DMAX)) d_clamp = (DW+8)'(DMAX);
      else d_clamp = d_full[DW+7:0];

      // tap positions behind the write pointer
      back   = (DW+1)'(d_ff[DW+7:8]) + (DW+1)'(d_ff[7:0] != 8'd0);
      frac_c = (d_ff[7:0] != 8'd0) ? (9'd256 - 9'(d_ff[7:0])) : 9'd0;
      tsum   = (DW+2)'(widx_ff) + (DW+2)'(DELAY_DEPTH) - (DW+2)'(back);
      i0_c   = (tsum >= (DW+2)'(DELAY_DEPTH)) ? DW'(tsum - (DW+2)'(DELAY_DEPTH)) : DW'(tsum);
      i1_c   = (i0_c == DW'(DELAY_DEPTH - 1)) ? '0 : i0_c + 1'b1;

      wet_full = 52'(s0_ff) + ((52'(prod_ff) + 52'sd128) >>> 8);
      chf      = (52'(x_cur) <<< 16) + 52'(prod_ff) + 52'sd32768;

      // phaser frequency, capped below half the sample rate
      fsum  = 17'(cfg.base) + 17'(prod_ff[46:32]);
      f_cap = (fsum > 17'd32767) ? 15'h7fff : fsum[14:0];

      yv_full = ((52'(prod_ff) + 52'sd16384) >>> 15) + 52'(s_ff);
      yv      = sme_pkg::sat24(yv_full);
      sn_full = 52'(v_ff) - ((52'(prod_ff) + 52'sd16384) >>> 15);
      sn      = sme_pkg::sat24(sn_full);

      // channel result
      y_we  = 1'b0;
      y_val = x_cur;
      case (state_ff)
         sme_pkg::ST_T3: begin
            y_we  = 1'b1;
            y_val = sme_pkg::sat16((52'(prod_ff) + 52'sd32768) >>> 16);
         end
         sme_pkg::ST_C9: begin
            y_we  = 1'b1;
            y_val = sme_pkg::sat16(chf >>> 16);
         end
         sme_pkg::ST_POUT: begin
            y_we  = 1'b1;
            y_val = sme_pkg::sat16((52'(x_cur) + 52'(v_ff) + 52'sd1) >>> 1);
         end
         default: begin
            y_we = 1'b0;
         end
      endcase
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sme_pkg::ST_CLEAR: begin
            if (clr_ff == DAW'(2 * DELAY_DEPTH - 1)) state_in = sme_pkg::ST_IDLE;
         end
         sme_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (cfg.mode == sme_pkg::MODE_BYPASS) ? sme_pkg::ST_PUSH
                                                             : sme_pkg::ST_LFO;
            end
         end
         sme_pkg::ST_LFO: begin
            case (cfg.mode)
               sme_pkg::MODE_CHORUS: state_in = sme_pkg::ST_C1;
               sme_pkg::MODE_PHASER: state_in = sme_pkg::ST_P1;
               default:              state_in = sme_pkg::ST_T1;
            endcase
         end
         sme_pkg::ST_T1:  state_in = sme_pkg::ST_T2;
         sme_pkg::ST_T2:  state_in = sme_pkg::ST_T3;
         sme_pkg::ST_T3:  state_in = sme_pkg::ST_NEXT;
         sme_pkg::ST_C1:  state_in = sme_pkg::ST_C2;
         sme_pkg::ST_C2:  state_in = sme_pkg::ST_C3;
         sme_pkg::ST_C3:  state_in = sme_pkg::ST_C4;
         sme_pkg::ST_C4:  state_in = sme_pkg::ST_C5;
         sme_pkg::ST_C5:  state_in = sme_pkg::ST_C6;
         sme_pkg::ST_C6:  state_in = sme_pkg::ST_C7;
         sme_pkg::ST_C7:  state_in = sme_pkg::ST_C8;
         sme_pkg::ST_C8:  state_in = sme_pkg::ST_C9;
         sme_pkg::ST_C9:  state_in = sme_pkg::ST_NEXT;
         sme_pkg::ST_P1:  state_in = sme_pkg::ST_P2;
         sme_pkg::ST_P2:  state_in = sme_pkg::ST_P3;
         sme_pkg::ST_P3:  state_in = sme_pkg::ST_PRD;
         sme_pkg::ST_PRD: state_in = sme_pkg::ST_PM1;
         sme_pkg::ST_PM1: state_in = sme_pkg::ST_PY;
         sme_pkg::ST_PY:  state_in = sme_pkg::ST_PM2;
         sme_pkg::ST_PM2: state_in = sme_pkg::ST_PWR;
         sme_pkg::ST_PWR: begin
            state_in = (stg_ff == SW'(ALLPASS_STAGES - 1)) ? sme_pkg::ST_POUT
                                                           : sme_pkg::ST_PRD;
         end
         sme_pkg::ST_POUT: state_in = sme_pkg::ST_NEXT;
         sme_pkg::ST_NEXT: state_in = ch_ff ? sme_pkg::ST_PUSH : sme_pkg::ST_LFO;
         sme_pkg::ST_PUSH: begin
            if (slot_free) state_in = sme_pkg::ST_IDLE;
         end
         default: state_in = sme_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control counters ----------------
   always_comb begin
      ch_in    = ch_ff;
      phase_in = phase_ff;
      widx_in  = widx_ff;
      clr_in   = clr_ff;
      stg_in   = stg_ff;
      case (state_ff)
         sme_pkg::ST_CLEAR: clr_in = clr_ff + 1'b1;
         sme_pkg::ST_IDLE:  ch_in  = 1'b0;
         sme_pkg::ST_P3:    stg_in = '0;
         sme_pkg::ST_PWR:   stg_in = stg_ff + 1'b1;
         sme_pkg::ST_NEXT: begin
            if (!ch_ff) begin
               ch_in = 1'b1;
            end else begin
               phase_in = phase_ff + cfg.step;
               if (cfg.mode == sme_pkg::MODE_CHORUS) begin
                  widx_in = (widx_ff == DW'(DELAY_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
               end
            end
         end
         default: begin
            ch_in = ch_ff;
         end
      endcase
   end

   // ---------------- outputs: multiplier operands, RAM control ----------------
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      dly_we    = 1'b0;
      dly_waddr = ch_ff ? DAW'(DELAY_DEPTH) + DAW'(widx_ff) : DAW'(widx_ff);
      dly_wdata = x_cur;
      dly_raddr = ch_ff ? DAW'(DELAY_DEPTH) + DAW'(i0_ff) : DAW'(i0_ff);
      ap_raddr  = ch_ff ? AAW'(ALLPASS_STAGES) + AAW'(stg_ff) : AAW'(stg_ff);
      ap_waddr  = ap_raddr;
      ap_wdata  = sn;
      ap_we     = 1'b0;
      stat.ready = (state_ff == sme_pkg::ST_IDLE);
      stat.done  = (state_ff == sme_pkg::ST_PUSH) && slot_free;
      case (state_ff)
         sme_pkg::ST_CLEAR: begin
            dly_we    = 1'b1;
            dly_waddr = clr_ff;
            dly_wdata = '0;
            ap_we     = (clr_ff < DAW'(2 * ALLPASS_STAGES));
            ap_waddr  = clr_ff[AAW-1:0];
            ap_wdata  = '0;
         end
         sme_pkg::ST_T1: begin
            mul_a = 32'(cfg.amount);
            mul_b = 18'sd32768 - 18'(sine_q_ff);
         end
         sme_pkg::ST_T2: begin
            mul_a = 32'(x_cur);
            mul_b = 18'sd65536 - $signed({2'b00, prod_ff[31:16]});
         end
         sme_pkg::ST_C1: begin
            dly_we = 1'b1;
            mul_a  = 32'(cfg.swing);
            mul_b  = 18'(sine_q_ff);
         end
         sme_pkg::ST_C5: begin
            dly_raddr = ch_ff ? DAW'(DELAY_DEPTH) + DAW'(i1_ff) : DAW'(i1_ff);
         end
         sme_pkg::ST_C6: begin
            mul_a = 32'(17'($signed(dly_rdata)) - 17'(s0_ff));
            mul_b = 18'(frac_ff);
         end
         sme_pkg::ST_C8: begin
            mul_a = 32'(17'(wet_ff) - 17'(x_cur));
            mul_b = 18'(cfg.amount);
         end
         sme_pkg::ST_P1: begin
            mul_a = 32'(cfg.amount);
            mul_b = 18'(cfg.span);
         end
         sme_pkg::ST_P2: begin
            mul_a = prod_ff[31:0];
            mul_b = 18'sd32768 + 18'(sine_q_ff);
         end
         sme_pkg::ST_PM1: begin
            mul_a = 32'(v_ff);
            mul_b = 18'(coef_q_ff);
         end
         sme_pkg::ST_PM2: begin
            mul_a = 32'(y24_ff);
            mul_b = 18'(coef_q_ff);
         end
         sme_pkg::ST_PWR: begin
            ap_we = 1'b1;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod_in = 50'(mul_a) * 50'(mul_b);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::ST_CLEAR;
         ch_ff    <= 1'b0;
         phase_ff <= '0;
         widx_ff  <= '0;
         clr_ff   <= '0;
         stg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         phase_ff <= phase_in;
         widx_ff  <= widx_in;
         clr_ff   <= clr_in;
         stg_ff   <= stg_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (y_we) begin
         if (ch_ff) yr_ff <= y_val;
         else yl_ff <= y_val;
      end
      case (state_ff)
         sme_pkg::ST_IDLE: begin
            if (start) begin
               xl_ff <= left_in;
               xr_ff <= right_in;
               yl_ff <= left_in;
               yr_ff <= right_in;
            end
         end
         sme_pkg::ST_C2: d_ff <= d_clamp;
         sme_pkg::ST_C3: begin
            i0_ff   <= i0_c;
            i1_ff   <= i1_c;
            frac_ff <= frac_c;
         end
         sme_pkg::ST_C5: s0_ff  <= $signed(dly_rdata);
         sme_pkg::ST_C7: wet_ff <= wet_full[15:0];
         sme_pkg::ST_P3: begin
            f_ff <= f_cap;
            v_ff <= 24'(x_cur);
         end
         sme_pkg::ST_PM1: s_ff   <= $signed(ap_rdata);
         sme_pkg::ST_PY:  y24_ff <= yv;
         sme_pkg::ST_PWR: v_ff   <= y24_ff;
         default: begin
            d_ff <= d_ff;
         end
      endcase
   end

   assign left_out  = yl_ff;
   assign right_out = yr_ff;

endmodule

`default_nettype wire

// File: sv/stereo_modulation_effect_core.sv
// Stereo chorus / phaser / tremolo core: register bank, result register, engine.
// Depends on sme_pkg, sme_engine (which uses sme_ram).
//
// Usage: one stereo sample pair enters on req_* as a beat; one processed pair
// leaves on rsp_*. Registers are written on csr_* (index = register number,
// writes beyond the list are dropped); write them only while the core is idle.
// Each accepted req beat is processed left channel first, then right, except
// in bypass; one sample pair is in work at a time, since the engine takes
// a new beat only while idle and shares one multiplier between all steps.
// The result sits in an output register, so the next pair is accepted while
// an earlier result waits for rsp_tready; the engine stalls only if a second
// result is done before the first one is taken.
// Reset: registers go to zero, then a clearing pass zeroes the whole delay line
// and the allpass state; req_tready stays low meanwhile.
`default_nettype none

module stereo_modulation_effect_core #(
   parameter int DELAY_DEPTH     = 2048,
   parameter int ALLPASS_STAGES  = 4,
   parameter int SINE_TABLE_SIZE = 1024,
   parameter int COEF_TABLE_SIZE = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input stream: tdata = left_in[15:0], right_in[31:16]
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [31:0]                 req_tdata,
   // result stream: tdata = left_out[15:0], right_out[31:16]
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [31:0]                      rsp_tdata,
   // register writes
   input  wire logic                        csr_wen,
   input  wire logic [sme_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [sme_pkg::CSR_DW-1:0]  csr_wdata
);

   sme_pkg::cfg_type      cfg_ff, cfg_in;
   sme_pkg::eng_stat_type stat;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  slot_free;
   logic                  start;
   logic signed [15:0]    y_left, y_right;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = stat.ready;
   assign start      = req_tvalid && stat.ready;

   // register bank writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            sme_pkg::REG_MODE:   cfg_in.mode   = csr_wdata[1:0];
            sme_pkg::REG_AMOUNT: cfg_in.amount = csr_wdata[15:0];
            sme_pkg::REG_STEP:   cfg_in.step   = csr_wdata[15:0];
            sme_pkg::REG_CENTER: cfg_in.center = csr_wdata[18:0];
            sme_pkg::REG_SWING:  cfg_in.swing  = csr_wdata[18:0];
            sme_pkg::REG_BASE:   cfg_in.base   = csr_wdata[14:0];
            sme_pkg::REG_SPAN:   cfg_in.span   = csr_wdata[14:0];
            default:             cfg_in        = cfg_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {y_right, y_left};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   sme_engine #(
      .DELAY_DEPTH     (DELAY_DEPTH),
      .ALLPASS_STAGES  (ALLPASS_STAGES),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
      .COEF_TABLE_SIZE (COEF_TABLE_SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .left_in   (req_tdata[15:0]),
      .right_in  (req_tdata[31:16]),
      .slot_free (slot_free),
      .stat      (stat),
      .left_out  (y_left),
      .right_out (y_right)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_stereo_modulation_effect_core.sv
// Self-checking testbench for stereo_modulation_effect_core: bypass, chorus, phaser and
// tremolo beats are checked against an in-bench fixed-point predictor. Depends on sme_pkg.
`default_nettype none

module tb_stereo_modulation_effect_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 2048;
   localparam int STAGES    = 4;
   localparam int SINE_N    = 1024;
   localparam int COEF_N    = 1024;
   localparam int SETTLE    = 80;      // beyond the longest engine latency
   localparam int IDLE_STOP = 20000;   // covers the clearing pass after reset

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata = '0;   // left_in[15:0], right_in[31:16]
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [31:0]                  rsp_tdata;        // left_out[15:0], right_out[31:16]
   logic                         csr_wen = 1'b0;
   logic [sme_pkg::CSR_AW-1:0]   csr_addr = '0;
   logic [sme_pkg::CSR_DW-1:0]   csr_wdata = '0;

   stereo_modulation_effect_core uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wen, .csr_addr, .csr_wdata
   );

   always #10 clock = ~clock;

   typedef struct {
      logic [15:0] left;
      logic [15:0] right;
   } pair_t;

   pair_t       pending_pairs[$];
   int          errors = 0;
   bit          calm = 1'b0;   // no idling on either side while set

   // predictor copy of registers and state
   logic [1:0]  p_mode;
   logic [15:0] p_amount, p_step, p_phase;
   logic [18:0] p_center, p_swing;
   logic [14:0] p_base, p_span;
   logic signed [15:0] echo_mem[2][DEPTH];
   int          echo_wr;
   longint      ap_mem[2][STAGES];
   longint      sine_lut[SINE_N];
   longint      coef_lut[COEF_N];

   // Q15 sine of r/65536 of a circle, odd Taylor series to the 11th power
   function automatic longint sine_q15(longint r);
      longint unsigned x, x2, term;
      longint sum;
      x    = (r * 64'd3373259426) / 32768;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         sum  = (k % 2) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      return (sum > 32767) ? 32767 : sum;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lim);
      return (v > lim - 1) ? lim - 1 : ((v < -lim) ? -lim : v);
   endfunction

   function automatic void build_luts();
      longint q, r, v, s, c;
      for (int i = 0; i < SINE_N; i++) begin
         q = ((i * 65536) / SINE_N) / 16384 % 4;
         r = ((i * 65536) / SINE_N) % 16384;
         v = (q % 2) ? sine_q15(16384 - r) : sine_q15(r);
         sine_lut[i] = (q >= 2) ? -v : v;
      end
      for (int i = 0; i < COEF_N; i++) begin
         s = sine_q15((i * 16384) / COEF_N);
         c = sine_q15(16384 - (i * 16384) / COEF_N);
         coef_lut[i] = clip(((s - c) * 32768) / (s + c), 32768);
      end
   endfunction

   function automatic void clear_model();
      {p_mode, p_amount, p_step, p_center, p_swing, p_base, p_span, p_phase} = '0;
      echo_wr = 0;
      foreach (echo_mem[c, i]) echo_mem[c][i] = '0;
      foreach (ap_mem[c, i]) ap_mem[c][i] = 0;
   endfunction

   function automatic longint chorus_out(longint x, longint lfo, int ch);
      longint d, ip, fr, back, frac, i0, s0, s1, wet;
      d = longint'(p_center) + round_shift(longint'(p_swing) * lfo, 15);
      if (d < 0) d = 0;
      if (d > (DEPTH - 1) * 256) d = (DEPTH - 1) * 256;
      echo_mem[ch][echo_wr] = x[15:0];
      ip   = d >> 8;
      fr   = d & 255;
      back = fr ? ip + 1 : ip;
      frac = fr ? 256 - fr : 0;
      i0   = (echo_wr + DEPTH - back) % DEPTH;
      s0   = echo_mem[ch][i0];
      s1   = echo_mem[ch][(i0 + 1) % DEPTH];
      wet  = s0 + round_shift((s1 - s0) * frac, 8);
      return clip(round_shift(x * (65536 - longint'(p_amount)) + wet * p_amount, 16), 32768);
   endfunction

   function automatic longint phaser_out(longint x, longint lfo, int ch);
      longint f, a, v, y;
      f = p_base + ((longint'(p_amount) * p_span * (lfo + 32768)) >>> 32);
      if (f > 32767) f = 32767;
      a = coef_lut[(f * COEF_N) >>> 15];
      v = x;
      for (int i = 0; i < STAGES; i++) begin
         y = clip(round_shift(a * v, 15) + ap_mem[ch][i], 8388608);
         ap_mem[ch][i] = clip(v - round_shift(a * y, 15), 8388608);
         v = y;
      end
      return clip(round_shift(x + v, 1), 32768);
   endfunction

   // expected output pair for one accepted input pair; advances predictor state
   function automatic pair_t process_pair(logic [31:0] beat);
      longint x[2], y[2], lfo, gain;
      logic [15:0] ph;
      pair_t res;
      x[0] = longint'($signed(beat[15:0]));
      x[1] = longint'($signed(beat[31:16]));
      y = x;
      if (p_mode != sme_pkg::MODE_BYPASS) begin
         for (int ch = 0; ch < 2; ch++) begin
            ph  = p_phase + (ch ? 16'd16384 : 16'd0);
            lfo = sine_lut[(longint'(ph) * SINE_N) >> 16];
            case (p_mode)
               sme_pkg::MODE_CHORUS: y[ch] = chorus_out(x[ch], lfo, ch);
               sme_pkg::MODE_PHASER: y[ch] = phaser_out(x[ch], lfo, ch);
               default: begin
                  gain  = 65536 - ((longint'(p_amount) * (32768 - lfo)) >> 16);
                  y[ch] = clip(round_shift(x[ch] * gain, 16), 32768);
               end
            endcase
         end
         if (p_mode == sme_pkg::MODE_CHORUS) echo_wr = (echo_wr + 1) % DEPTH;
         p_phase = p_phase + p_step;
      end
      res.left  = y[0][15:0];
      res.right = y[1][15:0];
      return res;
   endfunction

   function automatic bit roll_idle();
      return !calm && ($urandom_range(0, 99) < 37);
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // one register write; upper junk bits must be dropped by the core
   task automatic write_reg(logic [sme_pkg::CSR_AW-1:0] idx, logic [18:0] val);
      logic [18:0] junk;
      junk = 19'($urandom);
      case (idx)
         sme_pkg::REG_MODE:   begin p_mode   = val[1:0];  junk[1:0]  = val[1:0];  end
         sme_pkg::REG_AMOUNT: begin p_amount = val[15:0]; junk[15:0] = val[15:0]; end
         sme_pkg::REG_STEP:   begin p_step   = val[15:0]; junk[15:0] = val[15:0]; end
         sme_pkg::REG_CENTER: begin p_center = val;       junk       = val;       end
         sme_pkg::REG_SWING:  begin p_swing  = val;       junk       = val;       end
         sme_pkg::REG_BASE:   begin p_base   = val[14:0]; junk[14:0] = val[14:0]; end
         sme_pkg::REG_SPAN:   begin p_span   = val[14:0]; junk[14:0] = val[14:0]; end
         default: ;
      endcase
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= junk;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(logic [1:0] mode, logic [15:0] amount, logic [15:0] step,
                        logic [18:0] center, logic [18:0] swing,
                        logic [14:0] base, logic [14:0] span);
      write_reg(sme_pkg::REG_MODE, mode);
      write_reg(sme_pkg::REG_AMOUNT, amount);
      write_reg(sme_pkg::REG_STEP, step);
      write_reg(sme_pkg::REG_CENTER, center);
      write_reg(sme_pkg::REG_SWING, swing);
      write_reg(sme_pkg::REG_BASE, base);
      write_reg(sme_pkg::REG_SPAN, span);
   endtask

   // send one stereo beat and queue its expected result
   task automatic send_pair(logic [15:0] left, logic [15:0] right);
      while (roll_idle()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_pairs.push_back(process_pair({right, left}));
   endtask

   // sender holds off until every result is back and the engine has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_extremes();
      send_pair(16'h7fff, 16'h8000);
      send_pair(16'h8000, 16'h7fff);
      send_pair(16'h0000, 16'hffff);
   endtask

   task automatic test_bypass();
      setup(sme_pkg::MODE_BYPASS, 16'hffff, 16'h1234, '0, '0, '0, '0);
      send_extremes();
      drain();
   endtask

   // tremolo after bypass shows that the LFO held during bypass
   task automatic test_tremolo();
      write_reg(sme_pkg::REG_MODE, sme_pkg::MODE_TREMOLO);
      send_extremes();
      drain();
      write_reg(sme_pkg::REG_AMOUNT, 16'h0000);
      send_pair(16'h7fff, 16'h8000);
      drain();
   endtask

   // delay clamped at both ends, then a short sweeping tap
   task automatic test_chorus();
      setup(sme_pkg::MODE_CHORUS, 16'h8000, 16'h0400, 19'h7ffff, 19'h7ffff, '0, '0);
      send_extremes();
      drain();
      setup(sme_pkg::MODE_CHORUS, 16'hffff, 16'h0fff, 19'd0, 19'h7ffff, '0, '0);
      send_extremes();
      drain();
      setup(sme_pkg::MODE_CHORUS, 16'hc000, 16'h0800, 19'd600, 19'd300, '0, '0);
      for (int i = 0; i < 6; i++) send_pair(16'($urandom), 16'($urandom));
      drain();
   endtask

   // frequency saturating at half the sample rate, and the lowest coefficient
   task automatic test_phaser();
      setup(sme_pkg::MODE_PHASER, 16'hffff, 16'h2000, '0, '0, 15'h7fff, 15'h7fff);
      send_extremes();
      drain();
      setup(sme_pkg::MODE_PHASER, 16'h0000, 16'h0000, '0, '0, 15'h0000, 15'h0000);
      send_extremes();
      drain();
   endtask

   // a write to an index beyond the list must not disturb anything
   task automatic test_unknown_index();
      write_reg(sme_pkg::CSR_AW'(7), 19'h7ffff);
      send_pair(16'h1111, 16'heeee);
      drain();
   endtask

   task automatic random_config();
      logic [1:0] mode;
      mode = 2'($urandom);
      setup(mode,
            ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom),
            16'($urandom),
            ($urandom_range(0, 7) == 0) ? 19'($urandom) : 19'($urandom_range(0, 40 * 256)),
            ($urandom_range(0, 7) == 0) ? 19'($urandom) : 19'($urandom_range(0, 20 * 256)),
            15'($urandom), 15'($urandom));
   endtask

   task automatic test_random(int total);
      int sent, burst;
      sent = 0;
      while (sent < total) begin
         random_config();
         calm  = ($urandom_range(0, 5) == 0);
         burst = $urandom_range(20, 80);
         for (int i = 0; i < burst; i++) begin
            send_pair(16'($urandom), 16'($urandom));
         end
         sent += burst;
         drain();
      end
      calm = 1'b0;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      pair_t want;
      rsp_tready <= !roll_idle();
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[15:0], 16'h0000);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_tdata[15:0] !== want.left)
               report_mismatch("left_out", rsp_tdata[15:0], want.left);
            if (rsp_tdata[31:16] !== want.right)
               report_mismatch("right_out", rsp_tdata[31:16], want.right);
         end
      end
   end

   // watchdog on cycles without any accepted beat or register write
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_STOP) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      build_luts();
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_tremolo();
      test_chorus();
      test_phaser();
      test_unknown_index();
      test_random(800);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: stereo_modulation_effect_core.f
sv/sme_pkg.sv
sv/sme_ram.sv
sv/sme_engine.sv
sv/stereo_modulation_effect_core.sv
tb/sv/tb_stereo_modulation_effect_core.sv
